// ===== src/brf_pkg.sv =====
// Shared types, constants and microcode store of the bisection root finder.
package brf_pkg;

  localparam int ADDR_W = 5;
  localparam int UPC_W  = 5;
  localparam int STEP_W = 6;

  localparam logic [2:0] REG_CUBE   = 3'd0;
  localparam logic [2:0] REG_SQUARE = 3'd1;
  localparam logic [2:0] REG_LINEAR = 3'd2;
  localparam logic [2:0] REG_CONST  = 3'd3;
  localparam logic [2:0] REG_TOL    = 3'd4;

  localparam logic signed [31:0] RST_CUBE   = 32'sd65536;
  localparam logic signed [31:0] RST_SQUARE = 32'sd0;
  localparam logic signed [31:0] RST_LINEAR = -32'sd65536;
  localparam logic signed [31:0] RST_CONST  = -32'sd131072;
  localparam logic [30:0]        RST_TOL    = 31'd66;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic [UPC_W-1:0] UPC_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] UPC_LOOP = 5'd13;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_SIGN = 2'd1,
    ST_LIMIT   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] interval_low;
    logic signed [31:0] interval_high;
  } item_t;

  typedef struct packed {
    logic signed [31:0] root;
    status_e            status;
    logic [STEP_W-1:0]  steps_taken;
  } result_t;

  typedef struct packed {
    logic signed [31:0] cube;
    logic signed [31:0] square;
    logic signed [31:0] linear;
    logic signed [31:0] cnst;
    logic [30:0]        tol;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_ADD_SQ,
    OP_ADD_LIN,
    OP_FIN_A,
    OP_FIN_B,
    OP_FIN_M,
    OP_DECIDE
  } op_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_NO_START,
    JC_MORE
  } jc_e;

  typedef struct packed {
    op_e              op;
    jc_e              jc;
    logic [UPC_W-1:0] tgt;
    logic             fin;
  } ctrl_t;

  typedef struct packed {
    logic more;
  } flags_t;

  // Program: evaluate p(low), p(high), then loop evaluating the midpoint.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, jc: JC_NONE, tgt: UPC_IDLE, fin: 1'b0};
    unique case (pc)
      5'd0: begin
        c.op  = OP_LOAD;
        c.jc  = JC_NO_START;
        c.tgt = UPC_IDLE;
      end
      5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17: c.op = OP_MUL;
      5'd2, 5'd8, 5'd14:  c.op = OP_ADD_SQ;
      5'd4, 5'd10, 5'd16: c.op = OP_ADD_LIN;
      5'd6:  c.op = OP_FIN_A;
      5'd12: c.op = OP_FIN_B;
      5'd18: c.op = OP_FIN_M;
      5'd19: begin
        c.op  = OP_DECIDE;
        c.jc  = JC_MORE;
        c.tgt = UPC_LOOP;
        c.fin = 1'b1;
      end
      default: c.fin = 1'b1;
    endcase
    return c;
  endfunction

endpackage

// ===== src/bisection_root_finder.sv =====
// Top level of the bisection root finder for a configurable cubic polynomial.
// A transaction starts when start is high and busy is low; the interval ends
// are signed fixed point with FRAC_BITS fraction bits. One shared 32x32
// multiplier evaluates p(x) by Horner's rule, under a microcoded sequencer.
// The two end values are evaluated first, then one midpoint per halving;
// steps_taken (1 to MAX_STEPS) counts the halvings. The result is shown for
// exactly one cycle, which busy being low again, and must be taken then; the
// receiver cannot stall the block. Coefficients and tolerance are to be
// written over the APB port only while busy is low, by the user; the block
// itself does not enforce it.
module bisection_root_finder #(
  parameter int MAX_STEPS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  brf_pkg::item_t             item_i,
  output logic                       done_o,
  output brf_pkg::result_t           result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import brf_pkg::*;

  cfg_t   cfg;
  op_e    op;
  flags_t flags;

  brf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .flags_i (flags),
    .busy    (busy),
    .op_o    (op)
  );

  brf_dp #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .cfg_i    (cfg),
    .item_i   (item_i),
    .flags_o  (flags),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== src/brf_regs.sv =====
// APB-style configuration registers: polynomial coefficients and tolerance.
module brf_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output brf_pkg::cfg_t              cfg_o
);
  import brf_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cube   <= RST_CUBE;
      cfg_q.square <= RST_SQUARE;
      cfg_q.linear <= RST_LINEAR;
      cfg_q.cnst   <= RST_CONST;
      cfg_q.tol    <= RST_TOL;
    end else if (wr) begin
      unique case (idx)
        REG_CUBE:   cfg_q.cube   <= pwdata;
        REG_SQUARE: cfg_q.square <= pwdata;
        REG_LINEAR: cfg_q.linear <= pwdata;
        REG_CONST:  cfg_q.cnst   <= pwdata;
        REG_TOL:    cfg_q.tol    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CUBE:   prdata = cfg_q.cube;
      REG_SQUARE: prdata = cfg_q.square;
      REG_LINEAR: prdata = cfg_q.linear;
      REG_CONST:  prdata = cfg_q.cnst;
      REG_TOL:    prdata = {1'b0, cfg_q.tol};
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== src/brf_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jumps.
module brf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  brf_pkg::flags_t flags_i,
  output logic            busy,
  output brf_pkg::op_e    op_o
);
  import brf_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            ctrl;
  logic             taken;

  assign ctrl = ucode(upc_q);
  assign op_o = ctrl.op;
  assign busy = (upc_q != UPC_IDLE);

  always_comb begin
    unique case (ctrl.jc)
      JC_NO_START: taken = !start;
      JC_MORE:     taken = flags_i.more;
      default:     taken = 1'b0;
    endcase
    if (taken) begin
      upc_d = ctrl.tgt;
    end else if (ctrl.fin) begin
      upc_d = UPC_IDLE;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== src/brf_dp.sv =====
// Datapath: shared multiplier, Horner accumulate, interval ends and decision.
module brf_dp #(
  parameter int MAX_STEPS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brf_pkg::op_e     op_i,
  input  brf_pkg::cfg_t    cfg_i,
  input  brf_pkg::item_t   item_i,
  output brf_pkg::flags_t  flags_o,
  output logic             done_o,
  output brf_pkg::result_t result_o
);
  import brf_pkg::*;

  localparam int SH_W = 64 - FRAC_BITS;
  localparam int VW   = SH_W + 1;

  logic signed [31:0]  a_q, b_q, x_q, acc_q;
  logic signed [63:0]  prod_q;
  logic signed [VW-1:0] fa_q, fb_q, fm_q;
  logic [STEP_W-1:0]   steps_q;
  logic                done_q;
  result_t             res_q;

  logic signed [SH_W-1:0] sh;
  logic signed [31:0]     coef;
  logic signed [VW-1:0]   sum;
  logic signed [31:0]     acc_sat;
  logic [32:0]            s_ab, s_lo, s_hi, d_lo, d_hi;
  logic [31:0]            w_lo, w_hi, width;
  logic                   fm_zero, lo_opp, hi_opp, moved, near, at_lim, more;
  logic signed [31:0]     next_mid;

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic same;
    same = (&v[VW-1:31]) || (~|v[VW-1:31]);
    if (same) begin
      return v[31:0];
    end
    return v[VW-1] ? SAT_MIN : SAT_MAX;
  endfunction

  assign sh = prod_q[63:FRAC_BITS];

  always_comb begin
    unique case (op_i)
      OP_ADD_SQ:  coef = cfg_i.square;
      OP_ADD_LIN: coef = cfg_i.linear;
      default:    coef = cfg_i.cnst;
    endcase
  end

  assign sum     = {sh[SH_W-1], sh} + {{(VW-32){coef[31]}}, coef};
  assign acc_sat = sat32(sum);

  // floor((p + q) / 2) is the top 32 bits of the 33-bit sum
  assign s_ab = {a_q[31], a_q} + {b_q[31], b_q};
  assign s_lo = {a_q[31], a_q} + {x_q[31], x_q};
  assign s_hi = {x_q[31], x_q} + {b_q[31], b_q};
  assign d_lo = {x_q[31], x_q} - {a_q[31], a_q};
  assign d_hi = {b_q[31], b_q} - {x_q[31], x_q};
  assign w_lo = d_lo[32] ? 32'(-d_lo) : d_lo[31:0];
  assign w_hi = d_hi[32] ? 32'(-d_hi) : d_hi[31:0];

  // an end whose value is zero never counts as a sign change
  assign fm_zero  = (fm_q == '0);
  assign lo_opp   = (fa_q != '0) && (fa_q[VW-1] != fm_q[VW-1]);
  assign hi_opp   = (fb_q != '0) && (fb_q[VW-1] != fm_q[VW-1]);
  assign moved    = !fm_zero && (lo_opp || hi_opp);
  assign width    = lo_opp ? w_lo : w_hi;
  assign near     = (width <= {1'b0, cfg_i.tol});
  assign at_lim   = (steps_q >= STEP_W'(MAX_STEPS));
  assign more     = moved && !near && !at_lim;
  assign next_mid = lo_opp ? s_lo[32:1] : s_hi[32:1];

  assign flags_o.more = more;
  assign done_o       = done_q;
  assign result_o     = res_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        a_q     <= item_i.interval_low;
        b_q     <= item_i.interval_high;
        x_q     <= item_i.interval_low;
        acc_q   <= cfg_i.cube;
        steps_q <= '0;
      end
      OP_MUL: prod_q <= acc_q * x_q;
      OP_ADD_SQ, OP_ADD_LIN: acc_q <= acc_sat;
      OP_FIN_A: begin
        fa_q  <= sum;
        x_q   <= b_q;
        acc_q <= cfg_i.cube;
      end
      OP_FIN_B: begin
        fb_q  <= sum;
        x_q   <= s_ab[32:1];
        acc_q <= cfg_i.cube;
      end
      OP_FIN_M: begin
        fm_q    <= sum;
        steps_q <= steps_q + 1'b1;
      end
      OP_DECIDE: begin
        if (lo_opp) begin
          b_q  <= x_q;
          fb_q <= fm_q;
        end else begin
          a_q  <= x_q;
          fa_q <= fm_q;
        end
        x_q   <= next_mid;
        acc_q <= cfg_i.cube;
        res_q.steps_taken <= steps_q;
        if (fm_zero || (moved && near)) begin
          res_q.root   <= x_q;
          res_q.status <= ST_FOUND;
        end else if (!moved) begin
          res_q.root   <= '0;
          res_q.status <= ST_NO_SIGN;
        end else begin
          res_q.root   <= x_q;
          res_q.status <= ST_LIMIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (op_i == OP_DECIDE) && !more;
    end
  end

endmodule
